@@ src/sjf_pkg.sv @@
// ----------------------------------------------------------------------------
// sjf_pkg
// Shared types and constants of the shortest-job-first scheduler unit.
// ----------------------------------------------------------------------------
package sjf_pkg;

	localparam int MAX_PROCS_DEF = 16;
	localparam int ID_W          = 4;
	localparam int TIME_W        = 16;
	localparam int CMPL_W        = 21;
	localparam int TOT_W         = 25;
	localparam int S_DATA_W      = 40;
	localparam int M_DATA_W      = 168;

	// one stored job, job_id in the low bits
	typedef struct packed {
		logic [TIME_W-1:0] burst;
		logic [TIME_W-1:0] arrival;
		logic [ID_W-1:0]   job_id;
	} job_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	// result word payload, job fields in the low bits
	typedef struct packed {
		logic [TOT_W-1:0]  total_turnaround;
		logic [TOT_W-1:0]  total_waiting;
		logic [TIME_W-1:0] idle_before;
		logic [CMPL_W-1:0] waiting;
		logic [CMPL_W-1:0] turnaround;
		logic [CMPL_W-1:0] completion;
		job_t              job;
	} res_t;

endpackage

@@ src/sjf_alu.sv @@
// ----------------------------------------------------------------------------
// sjf_alu
// Shared add / subtract-compare unit. One adder serves every sum, difference
// and magnitude compare of the scheduler.
// ----------------------------------------------------------------------------
module sjf_alu #(
	parameter int DW = 26
) (
	input  sjf_pkg::alu_op_t op,
	input  logic [DW-1:0]    a,
	input  logic [DW-1:0]    b,
	output logic [DW-1:0]    res,
	output logic             lt
);
	import sjf_pkg::*;

	logic [DW:0]   sum;
	logic [DW-1:0] b_x;
	logic          is_sub;

	assign is_sub = (op == ALU_SUB);
	assign b_x    = is_sub ? ~b : b;
	assign sum    = {1'b0, a} + {1'b0, b_x} + (DW+1)'(is_sub);
	assign res    = sum[DW-1:0];
	// borrow out of a - b
	assign lt     = is_sub & ~sum[DW];

endmodule

@@ src/sjf_store.sv @@
// ----------------------------------------------------------------------------
// sjf_store
// Job store: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module sjf_store #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  sjf_pkg::job_t      wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr0,
	input  logic [AW-1:0]      raddr1,
	output sjf_pkg::job_t      rdata0,
	output sjf_pkg::job_t      rdata1
);
	import sjf_pkg::*;

	job_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

@@ src/sjf_seq.sv @@
// ----------------------------------------------------------------------------
// sjf_seq
// Sequencer: loads jobs, bubble-sorts the store by arrival, then for each slot
// idles, scans arrived jobs for the shortest burst, swaps it in and runs the
// completion / turnaround / waiting arithmetic through the shared ALU.
// ----------------------------------------------------------------------------
module sjf_seq #(
	parameter int MAX_PROCS = 16,
	parameter int AW        = 4,
	parameter int NW        = 5,
	parameter int DW        = 26
) (
	input  logic             clk,
	input  logic             arst_n,
	// job input
	input  logic             in_valid,
	input  sjf_pkg::job_t    in_job,
	input  logic             in_last,
	output logic             load_rdy,
	// result handoff
	output logic             res_load,
	output sjf_pkg::res_t    res,
	output logic             res_last,
	input  logic             res_ack,
	// job store
	output logic             mem_we,
	output logic [AW-1:0]    mem_waddr,
	output sjf_pkg::job_t    mem_wdata,
	output logic             mem_re,
	output logic [AW-1:0]    mem_raddr0,
	output logic [AW-1:0]    mem_raddr1,
	input  sjf_pkg::job_t    mem_rdata0,
	input  sjf_pkg::job_t    mem_rdata1,
	// shared ALU
	output sjf_pkg::alu_op_t alu_op,
	output logic [DW-1:0]    alu_a,
	output logic [DW-1:0]    alu_b,
	input  logic [DW-1:0]    alu_res,
	input  logic             alu_lt
);
	import sjf_pkg::*;

	typedef enum logic [3:0] {
		S_LOAD,
		S_SRT_RD,
		S_SRT_CMP,
		S_SRT_WR2,
		S_SCH_RD,
		S_SCH_IDLE,
		S_SCN_RD,
		S_SCN_ARR,
		S_SCN_BST,
		S_SWAP,
		S_SWAP2,
		S_ADD_C,
		S_SUB_T,
		S_SUB_W,
		S_ACC_W,
		S_ACC_T
	} state_t;

	localparam logic [NW-1:0] N_MAX = NW'(MAX_PROCS);

	state_t            state_q;
	logic              emit_q;
	logic              wait_q;
	logic [NW-1:0]     n_q;
	logic [NW-1:0]     i_q;
	logic [NW-1:0]     j_q;
	logic [NW-1:0]     pass_q;
	logic [AW-1:0]     pick_q;
	logic [DW-1:0]     clock_q;
	logic [DW-1:0]     sumw_q;
	logic [DW-1:0]     sumt_q;
	logic [DW-1:0]     tt_q;
	logic [DW-1:0]     wt_q;
	logic [TIME_W-1:0] idle_q;
	job_t              cur_q;
	job_t              best_q;

	logic          full;
	logic [NW-1:0] n_next;
	logic [NW:0]   j_plus2;
	logic [NW:0]   pass_plus2;
	logic [NW-1:0] i_plus1;
	logic [NW-1:0] j_plus1;
	logic          busy;

	assign busy       = emit_q | wait_q;
	assign full       = (n_q == N_MAX);
	assign n_next     = full ? n_q : n_q + NW'(1);
	assign j_plus2    = {1'b0, j_q} + (NW+1)'(2);
	assign pass_plus2 = {1'b0, pass_q} + (NW+1)'(2);
	assign i_plus1    = i_q + NW'(1);
	assign j_plus1    = j_q + NW'(1);

	assign load_rdy = (state_q == S_LOAD) & ~busy;
	assign res_load = emit_q;
	assign res_last = (i_plus1 == n_q);

	assign res.job              = best_q;
	assign res.completion       = clock_q[CMPL_W-1:0];
	assign res.turnaround       = tt_q[CMPL_W-1:0];
	assign res.waiting          = wt_q[CMPL_W-1:0];
	assign res.idle_before      = idle_q;
	assign res.total_waiting    = sumw_q[TOT_W-1:0];
	assign res.total_turnaround = sumt_q[TOT_W-1:0];

	// store and ALU drive
	always_comb begin
		mem_we     = 1'b0;
		mem_waddr  = j_q[AW-1:0];
		mem_wdata  = mem_rdata1;
		mem_re     = 1'b0;
		mem_raddr0 = j_q[AW-1:0];
		mem_raddr1 = AW'(j_q + NW'(1));
		alu_op     = ALU_SUB;
		alu_a      = clock_q;
		alu_b      = DW'(mem_rdata0.arrival);
		if (!busy) begin
			unique case (state_q)
				S_LOAD: begin
					mem_we    = in_valid & ~full;
					mem_waddr = n_q[AW-1:0];
					mem_wdata = in_job;
				end
				S_SRT_RD: begin
					mem_re = 1'b1;
				end
				S_SRT_CMP: begin
					// later slot arrives strictly earlier: swap
					alu_a  = DW'(mem_rdata1.arrival);
					alu_b  = DW'(mem_rdata0.arrival);
					mem_we = alu_lt;
				end
				S_SRT_WR2: begin
					mem_we    = 1'b1;
					mem_waddr = AW'(j_q + NW'(1));
					mem_wdata = mem_rdata0;
				end
				S_SCH_RD: begin
					mem_re     = 1'b1;
					mem_raddr0 = i_q[AW-1:0];
				end
				S_SCH_IDLE: begin
					alu_a = DW'(mem_rdata0.arrival);
					alu_b = clock_q;
				end
				S_SCN_RD: begin
					mem_re = 1'b1;
				end
				S_SCN_ARR: begin
					alu_a = clock_q;
					alu_b = DW'(mem_rdata0.arrival);
				end
				S_SCN_BST: begin
					alu_a = DW'(mem_rdata0.burst);
					alu_b = DW'(best_q.burst);
				end
				S_SWAP: begin
					mem_we    = (pick_q != i_q[AW-1:0]);
					mem_waddr = i_q[AW-1:0];
					mem_wdata = best_q;
				end
				S_SWAP2: begin
					mem_we    = 1'b1;
					mem_waddr = pick_q;
					mem_wdata = cur_q;
				end
				S_ADD_C: begin
					alu_op = ALU_ADD;
					alu_a  = clock_q;
					alu_b  = DW'(best_q.burst);
				end
				S_SUB_T: begin
					alu_a = clock_q;
					alu_b = DW'(best_q.arrival);
				end
				S_SUB_W: begin
					alu_a = tt_q;
					alu_b = DW'(best_q.burst);
				end
				S_ACC_W: begin
					alu_op = ALU_ADD;
					alu_a  = sumw_q;
					alu_b  = wt_q;
				end
				S_ACC_T: begin
					alu_op = ALU_ADD;
					alu_a  = sumt_q;
					alu_b  = tt_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			emit_q  <= 1'b0;
			wait_q  <= 1'b0;
			n_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			pass_q  <= '0;
			pick_q  <= '0;
			clock_q <= '0;
			sumw_q  <= '0;
			sumt_q  <= '0;
			tt_q    <= '0;
			wt_q    <= '0;
			idle_q  <= '0;
			cur_q   <= '0;
			best_q  <= '0;
		end else if (emit_q) begin
			emit_q <= 1'b0;
			wait_q <= 1'b1;
		end else if (wait_q) begin
			if (res_ack) begin
				wait_q <= 1'b0;
				if (res_last) begin
					n_q     <= '0;
					clock_q <= '0;
					sumw_q  <= '0;
					sumt_q  <= '0;
					state_q <= S_LOAD;
				end else begin
					i_q     <= i_plus1;
					state_q <= S_SCH_RD;
				end
			end
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						n_q <= n_next;
						if (in_last && n_next != '0) begin
							clock_q <= '0;
							sumw_q  <= '0;
							sumt_q  <= '0;
							i_q     <= '0;
							j_q     <= '0;
							pass_q  <= '0;
							state_q <= (n_next == NW'(1)) ? S_SCH_RD : S_SRT_RD;
						end
					end
				end
				S_SRT_RD: begin
					state_q <= S_SRT_CMP;
				end
				S_SRT_CMP, S_SRT_WR2: begin
					if (state_q == S_SRT_CMP && alu_lt) begin
						state_q <= S_SRT_WR2;
					end else if (j_plus2 == {1'b0, n_q}) begin
						j_q <= '0;
						if (pass_plus2 == {1'b0, n_q}) begin
							i_q     <= '0;
							state_q <= S_SCH_RD;
						end else begin
							pass_q  <= pass_q + NW'(1);
							state_q <= S_SRT_RD;
						end
					end else begin
						j_q     <= j_plus1;
						state_q <= S_SRT_RD;
					end
				end
				S_SCH_RD: begin
					state_q <= S_SCH_IDLE;
				end
				S_SCH_IDLE: begin
					cur_q  <= mem_rdata0;
					best_q <= mem_rdata0;
					pick_q <= i_q[AW-1:0];
					j_q    <= i_plus1;
					if (!alu_lt) begin
						idle_q  <= alu_res[TIME_W-1:0];
						clock_q <= DW'(mem_rdata0.arrival);
					end else begin
						idle_q <= '0;
					end
					state_q <= (i_plus1 == n_q) ? S_SWAP : S_SCN_RD;
				end
				S_SCN_RD: begin
					state_q <= S_SCN_ARR;
				end
				S_SCN_ARR: begin
					// scan stops at the first job not yet arrived
					state_q <= alu_lt ? S_SWAP : S_SCN_BST;
				end
				S_SCN_BST: begin
					if (alu_lt) begin
						best_q <= mem_rdata0;
						pick_q <= j_q[AW-1:0];
					end
					j_q     <= j_plus1;
					state_q <= (j_plus1 == n_q) ? S_SWAP : S_SCN_RD;
				end
				S_SWAP: begin
					state_q <= (pick_q != i_q[AW-1:0]) ? S_SWAP2 : S_ADD_C;
				end
				S_SWAP2: begin
					state_q <= S_ADD_C;
				end
				S_ADD_C: begin
					clock_q <= alu_res;
					state_q <= S_SUB_T;
				end
				S_SUB_T: begin
					tt_q    <= alu_res;
					state_q <= S_SUB_W;
				end
				S_SUB_W: begin
					wt_q    <= alu_res;
					state_q <= S_ACC_W;
				end
				S_ACC_W: begin
					sumw_q  <= alu_res;
					state_q <= S_ACC_T;
				end
				S_ACC_T: begin
					sumt_q <= alu_res;
					emit_q <= 1'b1;
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule

@@ src/sjf_nonpreemptive_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// sjf_nonpreemptive_scheduler_unit
// Non-preemptive shortest-job-first scheduler over a stored job set.
// ----------------------------------------------------------------------------
// Jobs load one word per cycle; up to MAX_PROCS are kept and later ones are
// dropped. The word with tlast set starts a run (a run with no stored jobs
// gives no output). The run first bubble-sorts the store by arrival, a read
// and compare per pair, two writes per swap, (n-1)^2 compares. Then each job
// idles to its arrival, scans arrived jobs for the shortest burst up to one
// not yet arrived, swaps it in and computes its times before its result word
// is offered; the next job starts the cycle after it is taken. Both phases
// are bounded by the single adder/compare unit and the single write port of
// the job store. No input is taken during a run or while a result word waits.
// After the tlast result the unit is ready to load the next set.
module sjf_nonpreemptive_scheduler_unit #(
	parameter int MAX_PROCS = sjf_pkg::MAX_PROCS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// job_id[3:0], arrival[19:4], burst[35:20], zero pad
	input  logic [sjf_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// job_out[3:0], arrival_out[19:4], burst_out[35:20], completion[56:36],
	// turnaround[77:57], waiting[98:78], idle_before[114:99],
	// total_waiting[139:115], total_turnaround[164:140], zero pad
	output logic [sjf_pkg::M_DATA_W-1:0]  m_tdata,
	output logic                          m_tlast
);
	import sjf_pkg::*;

	localparam int AW     = $clog2(MAX_PROCS);
	localparam int NW     = $clog2(MAX_PROCS + 1);
	localparam int DW_RAW = TIME_W + 2 * NW;
	localparam int DW     = (DW_RAW > TOT_W) ? DW_RAW : TOT_W;

	job_t          in_job;
	res_t          res;
	res_t          res_q;
	logic          res_load;
	logic          res_last;
	logic          last_q;
	logic          m_tvalid_q;
	logic          res_ack;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	job_t          mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr0;
	logic [AW-1:0] mem_raddr1;
	job_t          mem_rdata0;
	job_t          mem_rdata1;

	alu_op_t       alu_op;
	logic [DW-1:0] alu_a;
	logic [DW-1:0] alu_b;
	logic [DW-1:0] alu_res;
	logic          alu_lt;
	logic          load_rdy;

	assign in_job   = job_t'(s_tdata[$bits(job_t)-1:0]);
	assign s_tready = load_rdy;
	assign res_ack  = m_tvalid_q & m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_DATA_W'(res_q);
	assign m_tlast  = last_q;

	sjf_seq #(
		.MAX_PROCS (MAX_PROCS),
		.AW        (AW),
		.NW        (NW),
		.DW        (DW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_job     (in_job),
		.in_last    (s_tlast),
		.load_rdy   (load_rdy),
		.res_load   (res_load),
		.res        (res),
		.res_last   (res_last),
		.res_ack    (res_ack),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr0 (mem_raddr0),
		.mem_raddr1 (mem_raddr1),
		.mem_rdata0 (mem_rdata0),
		.mem_rdata1 (mem_rdata1),
		.alu_op     (alu_op),
		.alu_a      (alu_a),
		.alu_b      (alu_b),
		.alu_res    (alu_res),
		.alu_lt     (alu_lt)
	);

	sjf_store #(
		.DEPTH (MAX_PROCS),
		.AW    (AW)
	) u_store (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.re     (mem_re),
		.raddr0 (mem_raddr0),
		.raddr1 (mem_raddr1),
		.rdata0 (mem_rdata0),
		.rdata1 (mem_rdata1)
	);

	sjf_alu #(
		.DW (DW)
	) u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res),
		.lt  (alu_lt)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			last_q     <= 1'b0;
			res_q      <= '0;
		end else if (res_load) begin
			m_tvalid_q <= 1'b1;
			last_q     <= res_last;
			res_q      <= res;
		end else if (res_ack) begin
			m_tvalid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_no_load_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while a result word is pending");

	a_ready_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> s_tready)
		else $error("not ready to load after final result");

	a_turnaround_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (CMPL_W'(res_q.turnaround + res_q.job.arrival) == res_q.completion))
		else $error("completion differs from arrival plus turnaround");

	a_waiting_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (CMPL_W'(res_q.waiting + res_q.job.burst) == res_q.turnaround))
		else $error("turnaround differs from waiting plus burst");
`endif

endmodule
